// ===== src/disp_pkg.sv =====
// disp_pkg: shared constants for the decimal integer string parser.
// Character codes, field widths and the default digit limit.
// No dependencies.
package disp_pkg;

   localparam int unsigned CHAR_WIDTH   = 8;
   localparam int unsigned MAG_WIDTH    = 50;
   localparam int unsigned DIGIT_WIDTH  = 4;
   localparam int unsigned RSP_FIELDS_W = 2 + MAG_WIDTH;
   localparam int unsigned RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int unsigned MAX_DIGITS_DEFAULT = 15;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LF    = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_CR    = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;

endpackage

// ===== src/decimal_integer_string_parser_top.sv =====
// decimal_integer_string_parser_top: streaming ASCII decimal integer parser.
// Depends on disp_pkg for character codes and widths.
//
// Usage:
//   The req_ channel carries one string byte per transfer. Leading blanks
//   (space, tab, CR, LF) are skipped, one optional '+' or '-' may follow,
//   then 1 to MAX_DIGITS decimal digits and only trailing blanks.
//   A zero byte ends the string and produces exactly one transfer on the
//   rsp_ channel: accepted flag, sign and magnitude (zeros when rejected).
//   Non-zero bytes produce no result.
// Timing:
//   One byte per cycle while req_tready is high. The result appears on rsp_
//   in the cycle after the zero byte is taken. Each digit byte is one
//   multiply-by-ten (shift-add) step on the 50-bit accumulator between the parse state registers.
// Reset:
//   Synchronous, active high; the parser returns to the leading-blank phase
//   and the result register is emptied. After each zero byte the parser is
//   back in that same state, ready for the next string.
// Stalls:
//   The result register holds while rsp_tready is low; req_tready drops only
//   while a result is held and not being taken in the same cycle.
module decimal_integer_string_parser_top #(
   parameter int unsigned MAX_DIGITS = disp_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [disp_pkg::CHAR_WIDTH-1:0]   req_tdata,  // [7:0] char_byte
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [disp_pkg::RSP_DATA_W-1:0]   rsp_tdata   // [0] accepted,
                                                         // [1] negative,
                                                         // [51:2] magnitude,
                                                         // rest zero
);
   import disp_pkg::*;

   // digit counter must reach MAX_DIGITS+1 to flag overflow
   localparam int unsigned CNT_WIDTH = $clog2(MAX_DIGITS + 2);
   localparam logic [CNT_WIDTH-1:0] CNT_LIMIT = CNT_WIDTH'(MAX_DIGITS);
   localparam logic [CNT_WIDTH-1:0] CNT_ONE   = CNT_WIDTH'(1);

   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL,
      PH_REJECT
   } phase_type;

   phase_type              phase_ff,  phase_in;
   logic                   minus_ff,  minus_in;
   logic [CNT_WIDTH-1:0]   count_ff,  count_in;
   logic [MAG_WIDTH-1:0]   acc_ff,    acc_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_ok_ff,    rsp_ok_in;
   logic                   rsp_neg_ff,   rsp_neg_in;
   logic [MAG_WIDTH-1:0]   rsp_mag_ff,   rsp_mag_in;

   logic                   req_xfer;
   logic                   is_nul;
   logic                   is_blank;
   logic                   is_digit;
   logic [3:0]             digit_val;
   logic [MAG_WIDTH-1:0]   acc_step;
   logic [CNT_WIDTH-1:0]   count_step;
   logic                   string_ok;

   // output register frees when it is empty or being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_xfer   = req_tvalid && req_tready;

   // character classes
   always_comb begin
      is_nul    = (req_tdata == CHAR_NUL);
      is_blank  = req_tdata inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};
      is_digit  = req_tdata inside {[CHAR_ZERO:CHAR_NINE]};
      digit_val = 4'(req_tdata - CHAR_ZERO);
   end

   // acc*10 + digit as shift-add, wraps modulo 2^MAG_WIDTH
   assign acc_step   = (acc_ff << 3) + (acc_ff << 1) + MAG_WIDTH'(digit_val);
   assign count_step = count_ff + CNT_ONE;
   assign string_ok  = (phase_ff == PH_DIGITS) || (phase_ff == PH_TRAIL);

   // parse step
   always_comb begin
      phase_in = phase_ff;
      minus_in = minus_ff;
      count_in = count_ff;
      acc_in   = acc_ff;
      if (req_xfer) begin
         if (is_nul) begin
            phase_in = PH_LEAD;
            minus_in = 1'b0;
            count_in = '0;
            acc_in   = '0;
         end else begin
            case (phase_ff)
               PH_LEAD: begin
                  if (is_blank) begin
                     phase_in = PH_LEAD;
                  end else if (req_tdata == CHAR_MINUS) begin
                     minus_in = 1'b1;
                     phase_in = PH_SIGN;
                  end else if (req_tdata == CHAR_PLUS) begin
                     phase_in = PH_SIGN;
                  end else if (!is_digit) begin
                     phase_in = PH_REJECT;
                  end
               end
               PH_SIGN: begin
                  if (!is_digit) begin
                     phase_in = PH_REJECT;
                  end
               end
               PH_DIGITS: begin
                  if (is_blank) begin
                     phase_in = PH_TRAIL;
                  end else if (!is_digit) begin
                     phase_in = PH_REJECT;
                  end
               end
               PH_TRAIL: begin
                  if (!is_blank) begin
                     phase_in = PH_REJECT;
                  end
               end
               default: begin
                  phase_in = PH_REJECT;
               end
            endcase
            // digit taken in lead, sign or digit phase
            if (is_digit && (phase_ff == PH_LEAD || phase_ff == PH_SIGN ||
                             phase_ff == PH_DIGITS)) begin
               acc_in   = acc_step;
               count_in = count_step;
               phase_in = (count_step > CNT_LIMIT) ? PH_REJECT : PH_DIGITS;
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_neg_in   = rsp_neg_ff;
      rsp_mag_in   = rsp_mag_ff;
      if (req_xfer && is_nul) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = string_ok;
         rsp_neg_in   = string_ok && minus_ff;
         rsp_mag_in   = string_ok ? acc_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         minus_ff     <= 1'b0;
         count_ff     <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         minus_ff     <= minus_in;
         count_ff     <= count_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_ok_ff  <= rsp_ok_in;
      rsp_neg_ff <= rsp_neg_in;
      rsp_mag_ff <= rsp_mag_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_mag_ff, rsp_neg_ff, rsp_ok_ff});

`ifndef SYNTHESIS
   // a rejected string reports zero sign and magnitude
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (!rsp_neg_ff && rsp_mag_ff == '0))
      else $error("rejected result carries nonzero payload");

   // a terminator yields a result and clears the parse state
   a_nul_result: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_nul) |=>
         (rsp_valid_ff && phase_ff == PH_LEAD && count_ff == '0 && !minus_ff))
      else $error("terminator did not produce result and restart");

   // digit overflow always lands in the reject phase
   a_overflow_reject: assert property (@(posedge clock) disable iff (reset)
      (count_ff > CNT_LIMIT) |-> (phase_ff == PH_REJECT))
      else $error("digit count over limit without rejection");

   // digits counted only once a digit phase has been reached
   a_count_phase: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LEAD || phase_ff == PH_SIGN) |-> (count_ff == '0))
      else $error("digit count nonzero before digits");
`endif

endmodule

// ===== test/tb.sv =====
// tb: self-checking testbench for decimal_integer_string_parser_top.
// Streams zero-terminated strings byte by byte and checks every result transfer
// against a parser model or a typed expectation; depends on disp_pkg and the top-level RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import disp_pkg::*;

   localparam int unsigned DIGIT_LIMIT  = MAX_DIGITS_DEFAULT;
   localparam int unsigned TOTAL_ITEMS  = 1450;
   localparam int unsigned LONG_HOLD    = 300;   // cycles of the one long receiver hold

   // Parser phases, same encoding the block walks through.
   typedef enum logic [2:0] {
      PH_LEAD,
      PH_SIGN,
      PH_DIGITS,
      PH_TRAIL,
      PH_REJECT
   } parse_phase_type;

   // One parse result: the fields of rsp_tdata, packed here in the opposite order.
   typedef struct packed {
      logic                 accepted;
      logic                 negative;
      logic [MAG_WIDTH-1:0] magnitude;
   } number_type;

   localparam number_type REJECTED = '0;

   // Directed string with an optional hand-written expectation.
   typedef struct {
      string      text;
      bit         typed;
      number_type want;
   } probe_row_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_WIDTH-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Parser model state.
   parse_phase_type ph          = PH_LEAD;
   logic            minus_seen  = 1'b0;
   int unsigned     digit_count = 0;
   logic [63:0]     mag_acc     = '0;

   number_type    pending_numbers [$];   // results still owed by the block
   int unsigned   fail_count    = 0;
   int unsigned   item_count    = 0;     // bytes sent, directed and random
   bit            idle_on       = 1'b1;  // random gaps on both sides
   bit            hold_request  = 1'b0;  // ask the receiver for its long hold
   bit            hold_done     = 1'b0;

   // \015 is CR, \012 is LF; \377 and \200 exercise the top data bits.
   probe_row_type probe_rows [17] = '{
      '{"",                 1'b1, REJECTED},                  // empty string
      '{" \t\015\012",      1'b1, REJECTED},                  // blanks only
      '{"0",                1'b1, '{1'b1, 1'b0, 50'd0}},
      '{"-0",               1'b1, '{1'b1, 1'b1, 50'd0}},      // minus zero is kept
      '{"+7",               1'b0, REJECTED},
      '{"-",                1'b1, REJECTED},                  // sign, no digit
      '{"+ 5",              1'b1, REJECTED},
      '{"999999999999999",  1'b1, '{1'b1, 1'b0, 50'd999999999999999}},
      '{"-999999999999999", 1'b1, '{1'b1, 1'b1, 50'd999999999999999}},
      '{"1234567890123456", 1'b1, REJECTED},                  // one digit too many
      '{" \t-42 \015\012",  1'b0, REJECTED},
      '{"12a",              1'b1, REJECTED},                  // stray character
      '{"4 5",              1'b1, REJECTED},                  // digit after trailing blank
      '{"x\377\2009",       1'b1, REJECTED},                  // bytes dropped after reject
      '{"--1",              1'b1, REJECTED},
      '{"1-",               1'b1, REJECTED},
      '{"  +00123\t",       1'b0, REJECTED}
   };

   decimal_integer_string_parser_top #(
      .MAX_DIGITS (DIGIT_LIMIT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 2 ns clock.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well past the slowest legal run.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   function automatic bit is_blank(input logic [CHAR_WIDTH-1:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF;
   endfunction

   function automatic bit is_digit(input logic [CHAR_WIDTH-1:0] c);
      return c >= CHAR_ZERO && c <= CHAR_NINE;
   endfunction

   // Shift one decimal digit into the magnitude; too many digits rejects.
   function automatic void add_digit(input logic [CHAR_WIDTH-1:0] c);
      mag_acc     = mag_acc * 10 + {56'd0, c - CHAR_ZERO};
      digit_count = digit_count + 1;
      ph          = (digit_count > DIGIT_LIMIT) ? PH_REJECT : PH_DIGITS;
   endfunction

   // Advance the parser by one byte; returns 1 when the byte closes a string.
   function automatic bit parse_char(input logic [CHAR_WIDTH-1:0] c, output number_type res);
      res = REJECTED;
      if (c == CHAR_NUL) begin
         if (ph == PH_DIGITS || ph == PH_TRAIL) begin
            res.accepted  = 1'b1;
            res.negative  = minus_seen;
            res.magnitude = mag_acc[MAG_WIDTH-1:0];
         end
         ph          = PH_LEAD;
         minus_seen  = 1'b0;
         digit_count = 0;
         mag_acc     = '0;
         return 1'b1;
      end
      case (ph)
         PH_LEAD: begin
            if (is_blank(c)) begin
            end else if (c == CHAR_MINUS) begin
               minus_seen = 1'b1;
               ph         = PH_SIGN;
            end else if (c == CHAR_PLUS) begin
               ph = PH_SIGN;
            end else if (is_digit(c)) begin
               add_digit(c);
            end else begin
               ph = PH_REJECT;
            end
         end
         PH_SIGN: begin
            if (is_digit(c)) add_digit(c);
            else ph = PH_REJECT;
         end
         PH_DIGITS: begin
            if (is_digit(c)) add_digit(c);
            else if (is_blank(c)) ph = PH_TRAIL;
            else ph = PH_REJECT;
         end
         PH_TRAIL: begin
            if (!is_blank(c)) ph = PH_REJECT;
         end
         default: begin
            ph = PH_REJECT;
         end
      endcase
      return 1'b0;
   endfunction

   // One byte transfer on req_. Called at a rising edge; returns at the edge of
   // the transfer. An optional random gap drops tvalid first.
   task automatic send_byte(input logic [CHAR_WIDTH-1:0] b, input bit typed,
                            input number_type want);
      number_type res;
      bit         closes;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      item_count++;
      closes = parse_char(b, res);
      if (closes) pending_numbers.push_back(typed ? want : res);
   endtask

   // Send a string followed by its terminating zero byte.
   task automatic send_text(input logic [CHAR_WIDTH-1:0] text [$], input bit typed,
                            input number_type want);
      foreach (text[i]) send_byte(text[i], 1'b0, REJECTED);
      send_byte(CHAR_NUL, typed, want);
   endtask

   function automatic logic [CHAR_WIDTH-1:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // Random string: mostly well-formed numbers with random content, some
   // corrupted numbers, some plain noise.
   function automatic void build_text(ref logic [CHAR_WIDTH-1:0] text [$]);
      int unsigned kind;
      int unsigned r;
      int unsigned ndig;
      text.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(0, 6)) text.push_back(CHAR_WIDTH'($urandom_range(1, 255)));
         return;
      end
      repeat ($urandom_range(0, 3)) text.push_back(pick_blank());
      case ($urandom_range(0, 2))
         1: text.push_back(CHAR_PLUS);
         2: text.push_back(CHAR_MINUS);
         default: ;
      endcase
      // short numbers mostly, the full 15 digits now and then, overflow rarely
      r = $urandom_range(0, 19);
      if (r < 14) ndig = $urandom_range(1, 6);
      else if (r < 17) ndig = $urandom_range(7, DIGIT_LIMIT);
      else if (r == 17) ndig = DIGIT_LIMIT;
      else ndig = $urandom_range(DIGIT_LIMIT + 1, DIGIT_LIMIT + 2);
      repeat (ndig) text.push_back(CHAR_ZERO + CHAR_WIDTH'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 3)) text.push_back(pick_blank());
      if (kind == 1) text[$urandom_range(0, text.size() - 1)] = CHAR_WIDTH'($urandom_range(1, 255));
   endfunction

   // Receiver: random stall bursts, one long hold on request, all counted in
   // cycles here. Exactly one update of rsp_tready per edge.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request && !hold_done) begin
            hold_done  = 1'b1;
            stall_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result checker: every rsp_ transfer is matched with the oldest expectation.
   always @(posedge clock) begin
      number_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_numbers.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual %h",
                     $time, rsp_tdata);
            fail_count++;
         end else begin
            want = pending_numbers.pop_front();
            if (rsp_tdata[0] !== want.accepted) begin
               $display("%0t: accepted mismatch, expected %0d actual %0d",
                        $time, want.accepted, rsp_tdata[0]);
               fail_count++;
            end
            if (rsp_tdata[1] !== want.negative) begin
               $display("%0t: negative mismatch, expected %0d actual %0d",
                        $time, want.negative, rsp_tdata[1]);
               fail_count++;
            end
            if (rsp_tdata[MAG_WIDTH+1:2] !== want.magnitude) begin
               $display("%0t: magnitude mismatch, expected %0d actual %0d",
                        $time, want.magnitude, rsp_tdata[MAG_WIDTH+1:2]);
               fail_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:MAG_WIDTH+2] !== '0) begin
               $display("%0t: padding mismatch, expected 0 actual %h",
                        $time, rsp_tdata[RSP_DATA_W-1:MAG_WIDTH+2]);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, random strings, drain, verdict.
   initial begin
      logic [CHAR_WIDTH-1:0] text [$];
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed strings; rows with a typed expectation bypass the model's result
      foreach (probe_rows[i]) begin
         text.delete();
         for (int k = 0; k < probe_rows[i].text.len(); k++) text.push_back(probe_rows[i].text[k]);
         send_text(text, probe_rows[i].typed, probe_rows[i].want);
      end

      // random strings; long receiver hold early on, no gaps near the end
      while (item_count < TOTAL_ITEMS) begin
         if (item_count >= 300) hold_request = 1'b1;
         if (item_count >= TOTAL_ITEMS * 7 / 8) idle_on = 1'b0;
         build_text(text);
         send_text(text, 1'b0, REJECTED);
      end
      req_tvalid <= 1'b0;

      // drain, then wait on to catch any extra transfer
      while (pending_numbers.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
